// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions of the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef logic [31:0] word_t;

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	// Queue entry: one classified item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	function automatic word_t rotr(word_t v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

endpackage

// File: rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input items and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 item queue
// Front part: takes items, drops empty non-final ones, buffers the rest.
// ----------------------------------------------------------------------------
module sha256_queue import sha256_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	sha256_in_if.sink in_ch,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	item_t          mem_q [DEPTH];
	logic [AW-1:0]  rd_q, wr_q;
	logic [AW:0]    cnt_q;
	logic           push, keep;

	assign in_ch.ready = (cnt_q != (AW+1)'(DEPTH));
	assign keep = in_ch.byte_present | in_ch.end_of_message;
	assign push = in_ch.valid & in_ch.ready & keep;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

// File: rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Back part: packs bytes into the schedule, pads, runs rounds, emits digest.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	sha256_out_if.source out_ch
);
	state_t      state_q, state_d;
	word_t       h_q [8];
	word_t       w_q [16];
	word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [5:0]  rnd_q;
	logic        final_q;
	logic        pad_mark_q;
	logic        lenblk_q;
	logic        fin_q;
	logic [2:0]  idx_q;
	logic        shift_en;
	logic [7:0]  pbyte, sbyte;
	word_t       t1, t2, s0, s1, wn;
	logic [63:0] bits;

	assign bits = {len_q, 3'b000};

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25)) +
			((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + w_q[0];
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22)) +
			((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	// The block that carries the length gets its bytes from position 56 on.
	always_comb begin
		if (!pad_mark_q) pbyte = PAD_BYTE;
		else if (lenblk_q && fill_q >= LEN_POS) pbyte = bits[{~fill_q[2:0], 3'b000} +: 8];
		else pbyte = 8'h00;
	end

	assign sbyte = (state_q == ST_PAD) ? pbyte : q_item.data_byte;
	assign shift_en = (state_q == ST_LOAD && q_valid && q_item.byte_present) ||
		(state_q == ST_PAD);

	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.digest_word = h_q[idx_q];
	assign out_ch.word_index = idx_q;
	assign out_ch.last_word = (idx_q == 3'd7);
	assign q_pop = (state_q == ST_LOAD) & q_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (q_valid) begin
					if (q_item.byte_present && fill_q == 6'd63) state_d = ST_ROUND;
					else if (q_item.end_of_message) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (fill_q == 6'd63) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (fin_q) state_d = ST_EMIT;
				else if (final_q) state_d = ST_PAD;
				else state_d = ST_LOAD;
			end
			ST_EMIT: begin
				if (out_ch.ready && idx_q == 3'd7) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			pad_mark_q <= 1'b0;
			lenblk_q <= 1'b0;
			fin_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (q_item.byte_present) begin
							fill_q <= fill_q + 1'b1;
							len_q <= len_q + 1'b1;
						end
						final_q <= q_item.end_of_message;
					end
				end
				ST_PAD: begin
					pad_mark_q <= 1'b1;
					fill_q <= fill_q + 1'b1;
					if (!pad_mark_q) lenblk_q <= (fill_q <= 6'd55);
					if (fill_q == 6'd63) fin_q <= pad_mark_q & lenblk_q;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					lenblk_q <= 1'b1;
					if (fin_q) begin
						fin_q <= 1'b0;
						final_q <= 1'b0;
					end
					idx_q <= '0;
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= INIT_HASH[i];
							fill_q <= '0;
							len_q <= '0;
							pad_mark_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// The schedule window doubles as a 64-byte shift register while a block fills.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], sbyte};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
		if (state_d == ST_ROUND && state_q != ST_ROUND) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (state_q == ST_ROUND) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end
endmodule

// File: rtl/sha256_message_digest_top.sv
// Output: with an empty queue the first digest word shows once the final item's message has
// been padded and hashed, with an extra block when the padding needs one; then one word a cycle while ready is high.
// Throughput: one byte per cycle while a block fills, then the 64 rounds and the hash update
// run for each 64-byte block, during which bytes wait in the queue.
// Reset: arst_n asynchronously clears the queue and loads the initial hash.
// ----------------------------------------------------------------------------
// SHA-256 message digest top level
// Item queue in front of the compression engine.
// ----------------------------------------------------------------------------
module sha256_message_digest_top import sha256_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	sha256_in_if.sink in_ch,
	sha256_out_if.source out_ch
);
	logic  q_valid, q_pop;
	item_t q_item;

	sha256_queue #(.DEPTH(DEPTH)) u_queue (
		.clk, .arst_n, .in_ch, .q_valid, .q_item, .q_pop
	);
	sha256_core u_core (
		.clk, .arst_n, .q_valid, .q_item, .q_pop, .out_ch
	);
endmodule

// File: rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the output channel of the digest block.
// ----------------------------------------------------------------------------
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word,
	input logic [2:0]  out_index,
	input logic        out_last
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == 3'd7)))
		else $error("last_word does not match word_index");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_index == $past(out_index) + 3'd1)
		else $error("digest words not consecutive");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index))
		else $error("stalled digest word changed");
endmodule

bind sha256_message_digest_top sha256_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_word(out_ch.digest_word), .out_index(out_ch.word_index), .out_last(out_ch.last_word)
);
